[rtl/core/box_crop_centroid_tracker_assert.svh]
// assertion macros for the box crop centroid tracker checks
`ifndef BOX_CROP_CENTROID_TRACKER_ASSERT_SVH
`define BOX_CROP_CENTROID_TRACKER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define BCCT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("box crop centroid tracker check failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define BCCT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("box crop centroid tracker check failed");

`endif

[rtl/core/bcct_pkg.sv]
// types and constants shared by the box crop centroid tracker modules
`default_nettype none
package bcct_pkg;

	localparam int COORD_W    = 16;
	localparam int LIMIT_W    = 15;
	localparam int SEEN_W     = 17;
	localparam int CFG_DATA_W = 16;
	localparam int QUOT_W     = 17;

	localparam logic KIND_POINT    = 1'b0;
	localparam logic KIND_CENTROID = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

	typedef enum logic [1:0] {
		CFG_MAX_X       = 2'd0,
		CFG_MAX_Y       = 2'd1,
		CFG_MAX_Z_START = 2'd2,
		CFG_MARGIN      = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV_START,
		ST_DIV_RUN,
		ST_CENT
	} bcct_state_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x_mm;
		logic signed [COORD_W-1:0] y_mm;
		logic signed [COORD_W-1:0] z_mm;
		logic                      last_point;
	} in_item_t;

	typedef struct packed {
		logic                      kind;
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic [SEEN_W-1:0]         inliers_seen;
		logic                      cloud_empty;
		logic                      run_end;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic  accept;
		logic  div_start;
		axis_t axis;
		logic  load_cent;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cnt_zero;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[rtl/core/bcct_datapath.sv]
// datapath: box test, running sums, shared divider, result register
`default_nettype none
module bcct_datapath #(
	parameter int MAX_POINTS = 65536
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bcct_pkg::in_item_t                   in_data,
	input  bcct_pkg::cmd_t                       cmd,
	output bcct_pkg::sts_t                       sts,
	input  logic                                 cfg_valid,
	input  bcct_pkg::cfg_reg_t                   cfg_index,
	input  logic [bcct_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 out_stall,
	output logic                                 out_valid,
	output bcct_pkg::out_item_t                  out_data
);
	import bcct_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SW = COORD_W + CW;
	localparam int IW = $clog2(SW + 1);

	logic [LIMIT_W-1:0]        max_x_q;
	logic [LIMIT_W-1:0]        max_y_q;
	logic signed [COORD_W-1:0] margin_q;
	logic signed [COORD_W-1:0] z_limit_q;

	logic signed [SW-1:0] sum_x_q;
	logic signed [SW-1:0] sum_y_q;
	logic signed [SW-1:0] sum_z_q;
	logic [CW-1:0]        cnt_q;
	logic [CW-1:0]        cnt_inc;

	logic [COORD_W-1:0] abs_x;
	logic [COORD_W-1:0] abs_y;
	logic [COORD_W-1:0] abs_z;
	logic               inlier;
	logic               take;

	logic signed [SW-1:0] sel_sum;
	logic [SW-1:0]        mag_q;
	logic [CW-1:0]        rem_q;
	logic [QUOT_W-1:0]    quot_q;
	logic [IW-1:0]        iter_q;
	logic                 neg_q;
	axis_t                axis_q;
	logic [CW:0]          rem_sh;
	logic                 ge;
	logic [CW:0]          rem_nx;
	logic [QUOT_W-1:0]    quot_nx;
	logic [QUOT_W-1:0]    quot_sgn;

	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic signed [COORD_W-1:0] cz_q;
	logic signed [COORD_W:0]   z_next;
	logic signed [COORD_W-1:0] z_sat;

	logic      out_valid_q;
	out_item_t out_q;

	// box test on the incoming point
	always_comb begin
		abs_x = in_data.x_mm[COORD_W-1] ? COORD_W'(-in_data.x_mm) : COORD_W'(in_data.x_mm);
		abs_y = in_data.y_mm[COORD_W-1] ? COORD_W'(-in_data.y_mm) : COORD_W'(in_data.y_mm);
		abs_z = in_data.z_mm[COORD_W-1] ? COORD_W'(-in_data.z_mm) : COORD_W'(in_data.z_mm);
		inlier = (|{in_data.x_mm, in_data.y_mm, in_data.z_mm})
			&& (abs_x <= {1'b0, max_x_q})
			&& (abs_y <= {1'b0, max_y_q})
			&& !z_limit_q[COORD_W-1]
			&& (abs_z <= COORD_W'(z_limit_q))
			&& (cnt_q < CW'(MAX_POINTS));
		take    = cmd.accept && inlier;
		cnt_inc = cnt_q + 1'b1;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q  <= LIMIT_RESET;
			max_y_q  <= LIMIT_RESET;
			margin_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAX_X:  max_x_q  <= cfg_data[LIMIT_W-1:0];
				CFG_MAX_Y:  max_y_q  <= cfg_data[LIMIT_W-1:0];
				CFG_MARGIN: margin_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	// next z limit from centroid z plus margin, saturated
	always_comb begin
		z_next = (COORD_W+1)'(cz_q) + (COORD_W+1)'(margin_q);
		if (z_next[COORD_W] != z_next[COORD_W-1]) begin
			z_sat = z_next[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			z_sat = z_next[COORD_W-1:0];
		end
	end

	// z limit: written by software or moved by a non-empty cloud
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			z_limit_q <= {1'b0, LIMIT_RESET};
		end else if (cfg_valid && cfg_index == CFG_MAX_Z_START) begin
			z_limit_q <= {1'b0, cfg_data[LIMIT_W-1:0]};
		end else if (cmd.load_cent && cnt_q != '0) begin
			z_limit_q <= z_sat;
		end
	end

	// running sums and inlier count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.load_cent) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			cnt_q   <= '0;
		end else if (take) begin
			sum_x_q <= sum_x_q + SW'(in_data.x_mm);
			sum_y_q <= sum_y_q + SW'(in_data.y_mm);
			sum_z_q <= sum_z_q + SW'(in_data.z_mm);
			cnt_q   <= cnt_inc;
		end
	end

	// divider operand select and one restoring step
	always_comb begin
		case (cmd.axis)
			AXIS_X:  sel_sum = sum_x_q;
			AXIS_Y:  sel_sum = sum_y_q;
			default: sel_sum = sum_z_q;
		endcase
		rem_sh   = {rem_q, mag_q[SW-1]};
		ge       = rem_sh >= {1'b0, cnt_q};
		rem_nx   = ge ? (rem_sh - {1'b0, cnt_q}) : rem_sh;
		quot_nx  = {quot_q[QUOT_W-2:0], ge};
		quot_sgn = neg_q ? QUOT_W'(-quot_nx) : quot_nx;
	end

	// shared divider, one quotient bit per cycle on the magnitude
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (cmd.div_start) begin
			iter_q <= IW'(SW);
		end else if (iter_q != '0) begin
			iter_q <= iter_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			neg_q  <= sel_sum[SW-1];
			mag_q  <= sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);
			rem_q  <= '0;
			quot_q <= '0;
			axis_q <= cmd.axis;
		end else if (iter_q != '0) begin
			mag_q  <= {mag_q[SW-2:0], 1'b0};
			rem_q  <= rem_nx[CW-1:0];
			quot_q <= quot_nx;
		end
	end

	// centroid coordinates captured on the final step
	always_ff @(posedge clk) begin
		if (sts.div_done) begin
			case (axis_q)
				AXIS_X:  cx_q <= quot_sgn[COORD_W-1:0];
				AXIS_Y:  cy_q <= quot_sgn[COORD_W-1:0];
				default: cz_q <= quot_sgn[COORD_W-1:0];
			endcase
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_cent || take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (cmd.load_cent) begin
			out_q.kind    <= KIND_CENTROID;
			out_q.run_end <= 1'b1;
			if (cnt_q == '0) begin
				out_q.out_x        <= '0;
				out_q.out_y        <= '0;
				out_q.out_z        <= '0;
				out_q.inliers_seen <= '0;
				out_q.cloud_empty  <= 1'b1;
			end else begin
				out_q.out_x        <= cx_q;
				out_q.out_y        <= cy_q;
				out_q.out_z        <= cz_q;
				out_q.inliers_seen <= SEEN_W'(cnt_q);
				out_q.cloud_empty  <= 1'b0;
			end
		end else if (take) begin
			out_q.kind         <= KIND_POINT;
			out_q.out_x        <= in_data.x_mm;
			out_q.out_y        <= in_data.y_mm;
			out_q.out_z        <= in_data.z_mm;
			out_q.inliers_seen <= SEEN_W'(cnt_inc);
			out_q.cloud_empty  <= 1'b0;
			out_q.run_end      <= !in_data.last_point;
		end
	end

	assign sts.cnt_zero = (cnt_q == '0);
	assign sts.div_done = (iter_q == IW'(1));
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

endmodule
`default_nettype wire

[rtl/core/bcct_ctrl.sv]
// controller: point intake and end-of-cloud divide sequence
`default_nettype none
module bcct_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_point,
	output logic           in_stall,
	input  bcct_pkg::sts_t sts,
	output bcct_pkg::cmd_t cmd
);
	import bcct_pkg::*;

	bcct_state_t state_q;
	bcct_state_t state_d;
	axis_t       axis_q;
	axis_t       axis_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= AXIS_X;
		end else begin
			state_q <= state_d;
			axis_q  <= axis_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		axis_d   = axis_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall   = !sts.out_free;
				cmd.accept = in_valid && sts.out_free;
				if (cmd.accept && last_point) begin
					state_d = ST_CHECK;
					axis_d  = AXIS_X;
				end
			end
			ST_CHECK: begin
				state_d = sts.cnt_zero ? ST_CENT : ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				cmd.axis      = axis_q;
				state_d       = ST_DIV_RUN;
			end
			ST_DIV_RUN: begin
				if (sts.div_done) begin
					case (axis_q)
						AXIS_X: begin
							axis_d  = AXIS_Y;
							state_d = ST_DIV_START;
						end
						AXIS_Y: begin
							axis_d  = AXIS_Z;
							state_d = ST_DIV_START;
						end
						default: state_d = ST_CENT;
					endcase
				end
			end
			ST_CENT: begin
				if (sts.out_free) begin
					cmd.load_cent = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/box_crop_centroid_tracker.sv]
// top level of the box crop centroid tracker
`default_nettype none
// Point-cloud box crop with per-cloud centroid. Points with last_point low
// are taken back to back while the result register drains, and the input
// stalls only while a finished result is held by out_stall. The item with
// last_point high stalls the input after its transaction while the single
// shared restoring divider forms centroid x, y and z one after the other at
// one quotient bit per cycle; a cloud with no inliers skips the divider and
// goes straight to its centroid result.
// The centroid result may then wait in the result register for out_stall.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while no cloud end is in progress.
module box_crop_centroid_tracker #(
	parameter int MAX_POINTS = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  bcct_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output bcct_pkg::out_item_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  bcct_pkg::cfg_reg_t              cfg_index,
	input  logic [bcct_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bcct_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// sequencing
	bcct_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.last_point (in_data.last_point),
		.in_stall   (in_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	// arithmetic and storage
	bcct_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

[rtl/core/bcct_checker.sv]
// port-level checks on the tracker's result channel, bound to the top level
`default_nettype none
`include "box_crop_centroid_tracker_assert.svh"
module bcct_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire bcct_pkg::out_item_t out_data
);
	import bcct_pkg::*;

	// a held result transaction stays put
	`BCCT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// a point result never carries the empty flag
	`BCCT_ASSERT_IMP(a_point_not_empty, out_valid && out_data.kind == KIND_POINT, !out_data.cloud_empty)

	// an empty centroid is all zero and closes its item
	`BCCT_ASSERT_IMP(a_empty_zero, out_valid && out_data.kind == KIND_CENTROID && out_data.cloud_empty, out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0 && out_data.inliers_seen == 0 && out_data.run_end)

	// a point followed by its centroid is not chased by another point
	`BCCT_ASSERT_NXT(a_point_then_cent, out_valid && !out_stall && out_data.kind == KIND_POINT && !out_data.run_end, !out_valid || out_data.kind == KIND_CENTROID)

endmodule

bind box_crop_centroid_tracker bcct_checker u_bcct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
`default_nettype wire

[verif/tb_box_crop_centroid_tracker.sv]
// self-checking testbench for the box crop centroid tracker
`timescale 1ns / 100ps
module tb_box_crop_centroid_tracker;
	import bcct_pkg::*;

	localparam int INLIER_CAP  = 65536;
	localparam int CLK_LIMIT   = 8000000;
	localparam int DIV_SETTLE  = 110;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 175;

	// box crop and centroid predictor with its queue of owed outputs
	class cloud_predictor;
		int        x_lim;
		int        y_lim;
		int        z_start;
		int        z_lim;
		int        margin;
		longint    sum_x;
		longint    sum_y;
		longint    sum_z;
		int        count;
		out_item_t owed_q[$];
		int        errors;
		int        n_points;
		int        n_clouds;
		int        n_empty;
		int        n_inliers;
		int        n_cap_drops;
		int        n_writes;

		function new();
			x_lim   = 32767;
			y_lim   = 32767;
			z_start = 32767;
			z_lim   = 32767;
			margin  = 0;
			sum_x   = 0;
			sum_y   = 0;
			sum_z   = 0;
			count   = 0;
			errors  = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] val);
			n_writes++;
			case (idx)
				CFG_MAX_X:       x_lim = int'(val[14:0]);
				CFG_MAX_Y:       y_lim = int'(val[14:0]);
				CFG_MAX_Z_START: begin
					z_start = int'(val[14:0]);
					z_lim   = z_start;
				end
				CFG_MARGIN:      margin = int'($signed(val));
				default:         ;
			endcase
		endfunction

		function int pending();
			return owed_q.size();
		endfunction

		// crop one point, accumulate, and close the cloud on its last point
		function void take_point(in_item_t it);
			int        px;
			int        py;
			int        pz;
			bit        qualifies;
			longint    cx;
			longint    cy;
			longint    cz;
			longint    nz;
			out_item_t r;
			px = int'(it.x_mm);
			py = int'(it.y_mm);
			pz = int'(it.z_mm);
			n_points++;
			qualifies = (px != 0 || py != 0 || pz != 0) &&
				((px < 0) ? -px : px) <= x_lim &&
				((py < 0) ? -py : py) <= y_lim &&
				((pz < 0) ? -pz : pz) <= z_lim;
			if (qualifies && count < INLIER_CAP) begin
				sum_x += px;
				sum_y += py;
				sum_z += pz;
				count++;
				n_inliers++;
				r = '0;
				r.kind         = KIND_POINT;
				r.out_x        = it.x_mm;
				r.out_y        = it.y_mm;
				r.out_z        = it.z_mm;
				r.inliers_seen = SEEN_W'(count);
				r.run_end      = !it.last_point;
				owed_q.insert(owed_q.size(), r);
			end else if (qualifies) begin
				n_cap_drops++;
			end
			if (it.last_point) begin
				n_clouds++;
				r = '0;
				r.kind    = KIND_CENTROID;
				r.run_end = 1'b1;
				if (count == 0) begin
					r.cloud_empty = 1'b1;
					n_empty++;
				end else begin
					// signed division truncates toward zero
					cx = sum_x / count;
					cy = sum_y / count;
					cz = sum_z / count;
					nz = cz + margin;
					if (nz > 32767)
						nz = 32767;
					if (nz < -32768)
						nz = -32768;
					z_lim          = int'(nz);
					r.out_x        = cx[15:0];
					r.out_y        = cy[15:0];
					r.out_z        = cz[15:0];
					r.inliers_seen = SEEN_W'(count);
				end
				owed_q.insert(owed_q.size(), r);
				sum_x = 0;
				sum_y = 0;
				sum_z = 0;
				count = 0;
			end
		endfunction

		function void cmp_field(string name, longint want, longint got);
			if (want != got) begin
				$error("field %s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		// compare one output transaction with the oldest owed one
		function void check_output(out_item_t got);
			out_item_t want;
			if (owed_q.size() == 0) begin
				$error("output transaction with nothing owed: kind %0d x %0d",
					got.kind, got.out_x);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			cmp_field("kind", longint'(want.kind), longint'(got.kind));
			cmp_field("out_x", longint'(want.out_x), longint'(got.out_x));
			cmp_field("out_y", longint'(want.out_y), longint'(got.out_y));
			cmp_field("out_z", longint'(want.out_z), longint'(got.out_z));
			cmp_field("inliers_seen", longint'(want.inliers_seen),
				longint'(got.inliers_seen));
			cmp_field("cloud_empty", longint'(want.cloud_empty),
				longint'(got.cloud_empty));
			cmp_field("run_end", longint'(want.run_end), longint'(got.run_end));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	cfg_reg_t   cfg_index;
	logic [15:0] cfg_data;

	cloud_predictor sb = new();
	int burst_left = 0;
	bit hold_req = 1'b0;
	int cycles = 0;
	int n_settings = 0;

	box_crop_centroid_tracker #(
		.MAX_POINTS(INLIER_CAP)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// watchdog on the total run length
	initial begin
		while (cycles < CLK_LIMIT)
			@(posedge clk) cycles++;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// monitor both data channels at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			sb.take_point(in_data);
		if (arst_n && out_valid && !out_stall)
			sb.check_output(out_data);
	end

	// receiver stall pattern, with a long hold-off on request
	initial begin
		int pct;
		int mode_left;
		pct = 0;
		mode_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					case ($urandom_range(0, 3))
						0:       pct = 0;
						1:       pct = 20;
						2:       pct = 50;
						default: pct = 80;
					endcase
					mode_left = $urandom_range(20, 400);
				end
				mode_left--;
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	function automatic in_item_t pt(int x, int y, int z, bit last);
		in_item_t it;
		it.x_mm       = x[15:0];
		it.y_mm       = y[15:0];
		it.z_mm       = z[15:0];
		it.last_point = last;
		return it;
	endfunction

	// coordinate near the box edge, at the range ends, or anywhere
	function automatic logic [15:0] rand_coord(int lim);
		logic [15:0] raw;
		int          l;
		int          v;
		raw = 16'($urandom);
		l = (lim < 0) ? 0 : lim;
		case ($urandom_range(0, 9))
			0:       v = int'($signed(raw));
			1:       v = 0;
			2:       v = l;
			3:       v = -l;
			4:       v = l + 1;
			5:       v = -l - 1;
			6:       v = -32768;
			7:       v = 32767;
			default: v = int'($urandom_range(0, 2 * l)) - l;
		endcase
		if (v > 32767)
			v = 32767;
		return v[15:0];
	endfunction

	function automatic in_item_t make_point(bit last);
		in_item_t it;
		if ($urandom_range(0, 15) == 0)
			return pt(0, 0, 0, last);
		it.x_mm       = rand_coord(sb.x_lim);
		it.y_mm       = rand_coord(sb.y_lim);
		it.z_mm       = rand_coord(sb.z_lim);
		it.last_point = last;
		return it;
	endfunction

	// one input transaction, with random gaps between bursts
	task automatic send_item(input in_item_t it);
		in_item_t junk;
		int       gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
				$urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				junk.x_mm       = 16'($urandom);
				junk.y_mm       = 16'($urandom);
				junk.z_mm       = 16'($urandom);
				junk.last_point = 1'($urandom);
				in_valid <= 1'b0;
				in_data  <= junk;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic go_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic send_cloud(input int npts);
		for (int i = 0; i < npts; i++)
			send_item(make_point(i == npts - 1));
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// new limit set, written only once the block has gone quiet
	task automatic load_settings(input int xl, input int yl, input int zs, input int m);
		go_idle();
		wait_drained();
		repeat (DIV_SETTLE) @(posedge clk);
		n_settings++;
		write_reg(CFG_MAX_X, {1'($urandom), 15'(xl)});
		write_reg(CFG_MAX_Y, {1'($urandom), 15'(yl)});
		write_reg(CFG_MAX_Z_START, {1'($urandom), 15'(zs)});
		write_reg(CFG_MARGIN, 16'(m));
	endtask

	function automatic int rand_limit();
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 200) :
			$urandom_range(0, 32767);
	endfunction

	initial begin
		int       sent;
		int       npts;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_MAX_X;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset limits: range ends, an all-zero point, |x| of 32768 rejected
		send_item(pt(32767, -32767, 32767, 1'b0));
		send_item(pt(-32767, 32767, -32767, 1'b0));
		send_item(pt(0, 0, 0, 1'b0));
		send_item(pt(-32768, 5, 5, 1'b0));
		send_item(pt(1, 0, 0, 1'b1));

		// tight box with edges, then a margin that drives the z limit negative
		load_settings(100, 200, 300, -32768);
		send_item(pt(100, -200, 300, 1'b0));
		send_item(pt(101, 0, 0, 1'b0));
		send_item(pt(0, 201, 0, 1'b0));
		send_item(pt(0, 0, -301, 1'b0));
		send_item(pt(-100, 200, -300, 1'b0));
		send_item(pt(5, 5, 5, 1'b1));

		// negative z limit passes nothing, so both clouds come out empty
		send_item(pt(1, 1, 0, 1'b0));
		send_item(pt(-1, 2, -1, 1'b1));
		send_item(pt(0, 0, 0, 1'b1));

		// truncation toward zero and upward saturation of the z limit
		load_settings(32767, 32767, 32767, 32767);
		send_item(pt(-3, 7, 10, 1'b0));
		send_item(pt(-4, -2, 11, 1'b0));
		send_item(pt(2, -9, 10, 1'b1));
		send_item(pt(-7, 3, 32767, 1'b1));

		// random phases, each with its own limit set
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0:       load_settings(32767, 32767, 32767, 0);
				1:       load_settings(0, 5, 0, -32768);
				2:       load_settings(rand_limit(), rand_limit(), 32767, 32767);
				3:       load_settings(32767, 0, rand_limit(), $urandom_range(0, 65535) - 32768);
				default: load_settings(rand_limit(), rand_limit(), rand_limit(),
					($urandom_range(0, 1) == 0) ? $urandom_range(0, 400) - 200 :
					$urandom_range(0, 65535) - 32768);
			endcase
			if (phase == 0) begin
				// long receiver hold-off while points keep coming back to back
				hold_req = 1'b1;
				burst_left = 400;
				send_cloud(150);
				go_idle();
				wait_drained();
			end
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				npts = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 60) :
					$urandom_range(1, 20);
				send_cloud(npts);
				sent += npts;
			end
		end

		go_idle();
		wait_drained();
		repeat (DIV_SETTLE) @(posedge clk);
		$display("covered %0d clouds (%0d empty), %0d points, %0d inliers, %0d cap drops",
			sb.n_clouds, sb.n_empty, sb.n_points, sb.n_inliers, sb.n_cap_drops);
		$display("%0d register writes over %0d limit sets", sb.n_writes, n_settings);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
